### hdl/gbte_pkg.sv
// shared constants, types and helpers for the gap buffer text editor
// used by gbte_ctrl, gbte_dpath and gap_buffer_text_editor; no dependencies

package gbte_pkg;

   // storage size and derived widths
   localparam int CAPACITY = 256;
   localparam int ADDR_W   = $clog2(CAPACITY);
   localparam int CNT_W    = $clog2(CAPACITY + 1);

   // command codes
   localparam logic [3:0] CMD_FWD       = 4'd0;
   localparam logic [3:0] CMD_BACK      = 4'd1;
   localparam logic [3:0] CMD_START     = 4'd2;
   localparam logic [3:0] CMD_END       = 4'd3;
   localparam logic [3:0] CMD_INSERT    = 4'd4;
   localparam logic [3:0] CMD_DELETE    = 4'd5;
   localparam logic [3:0] CMD_WORD_FWD  = 4'd6;
   localparam logic [3:0] CMD_WORD_BACK = 4'd7;
   localparam logic [3:0] CMD_DEL_WORD  = 4'd8;
   localparam logic [3:0] CMD_READ      = 4'd9;

   // result status codes
   localparam logic [1:0] ST_OK    = 2'd0;
   localparam logic [1:0] ST_FULL  = 2'd1;
   localparam logic [1:0] ST_RANGE = 2'd2;

   // datapath operations, one per cycle
   localparam logic [2:0] OP_NONE = 3'd0;
   localparam logic [2:0] OP_FWD  = 3'd1;
   localparam logic [2:0] OP_BACK = 3'd2;
   localparam logic [2:0] OP_INS  = 3'd3;
   localparam logic [2:0] OP_DROP = 3'd4;

   typedef struct packed {
      logic [3:0] cmd;
      logic [7:0] ch;
      logic [7:0] index;
   } req_type;

   typedef struct packed {
      logic [7:0] char_out;
      logic [8:0] cursor;
      logic [8:0] length;
      logic [1:0] status;
   } rsp_type;

   // controller to datapath
   typedef struct packed {
      logic       latch;
      logic [2:0] op;
      logic       rd_index;
      logic       respond;
   } ctl_type;

   // datapath to controller
   typedef struct packed {
      logic [3:0] cmd;
      logic       before_empty;
      logic       after_empty;
      logic       full;
      logic       before_ws;
      logic       after_ws;
   } sts_type;

   // space or tab through carriage return
   function automatic logic is_space(input logic [7:0] c);
      is_space = (c == 8'h20) || ((c >= 8'h09) && (c <= 8'h0D));
   endfunction

endpackage

### hdl/gbte_ram.sv
// generic single write port, single read port ram with registered read
// write-first on a same-address collision; no dependencies

module gbte_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // write port
   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
   end

   // registered read, new data on collision
   always_ff @(posedge clock) begin
      if (we && (waddr == raddr)) begin
         rdata_ff <= wdata;
      end else begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

### hdl/gbte_ctrl.sv
// command sequencer: picks one datapath operation per cycle
// depends on gbte_pkg

module gbte_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  gbte_pkg::sts_type sts,
   output gbte_pkg::ctl_type ctl
);

   localparam logic [1:0] S_IDLE  = 2'd0;
   localparam logic [1:0] S_EXEC  = 2'd1;
   localparam logic [1:0] S_RDOUT = 2'd2;

   logic [1:0] state_ff, state_in;
   logic       first_ff, first_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         first_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         first_ff <= first_in;
      end
   end

   assign busy = (state_ff != S_IDLE);

   // next state and per-cycle operation
   always_comb begin
      state_in    = state_ff;
      first_in    = first_ff;
      ctl.latch    = 1'b0;
      ctl.op       = gbte_pkg::OP_NONE;
      ctl.rd_index = 1'b0;
      ctl.respond  = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               ctl.latch = 1'b1;
               first_in  = 1'b1;
               state_in  = S_EXEC;
            end
         end
         S_EXEC: begin
            first_in = 1'b0;
            case (sts.cmd)
               gbte_pkg::CMD_FWD: begin
                  if (!sts.after_empty) ctl.op = gbte_pkg::OP_FWD;
                  ctl.respond = 1'b1;
               end
               gbte_pkg::CMD_BACK: begin
                  if (!sts.before_empty) ctl.op = gbte_pkg::OP_BACK;
                  ctl.respond = 1'b1;
               end
               gbte_pkg::CMD_START: begin
                  if (!sts.before_empty) ctl.op = gbte_pkg::OP_BACK;
                  else ctl.respond = 1'b1;
               end
               gbte_pkg::CMD_END: begin
                  if (!sts.after_empty) ctl.op = gbte_pkg::OP_FWD;
                  else ctl.respond = 1'b1;
               end
               gbte_pkg::CMD_INSERT: begin
                  if (!sts.full) ctl.op = gbte_pkg::OP_INS;
                  ctl.respond = 1'b1;
               end
               gbte_pkg::CMD_DELETE: begin
                  if (!sts.after_empty) ctl.op = gbte_pkg::OP_DROP;
                  ctl.respond = 1'b1;
               end
               gbte_pkg::CMD_WORD_FWD: begin
                  if (sts.after_empty || (!first_ff && sts.after_ws)) ctl.respond = 1'b1;
                  else ctl.op = gbte_pkg::OP_FWD;
               end
               gbte_pkg::CMD_WORD_BACK: begin
                  if (sts.before_empty || (!first_ff && sts.before_ws)) ctl.respond = 1'b1;
                  else ctl.op = gbte_pkg::OP_BACK;
               end
               gbte_pkg::CMD_DEL_WORD: begin
                  if (sts.after_empty || (!first_ff && sts.after_ws)) ctl.respond = 1'b1;
                  else ctl.op = gbte_pkg::OP_DROP;
               end
               gbte_pkg::CMD_READ: begin
                  ctl.rd_index = 1'b1;
               end
               default: begin
                  ctl.respond = 1'b1;
               end
            endcase
            if (ctl.respond) state_in = S_IDLE;
            else if (ctl.rd_index) state_in = S_RDOUT;
         end
         S_RDOUT: begin
            ctl.respond = 1'b1;
            state_in    = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // a beat is taken only while idle
   a_latch_idle: assert property (@(posedge clock) disable iff (reset)
      ctl.latch |-> (state_ff == S_IDLE))
      else $error("request latched while busy");

   // the read beat always follows its address cycle
   a_rdout_seq: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_RDOUT) |-> $past(ctl.rd_index))
      else $error("read output without address cycle");

   // one response per command, then back to idle
   a_resp_idle: assert property (@(posedge clock) disable iff (reset)
      ctl.respond |=> (state_ff == S_IDLE))
      else $error("response without return to idle");

endmodule

### hdl/gbte_dpath.sv
// two-stack datapath: stack depths, the two character stores and the result register
// depends on gbte_pkg and gbte_ram

module gbte_dpath (
   input  logic              clock,
   input  logic              reset,
   input  gbte_pkg::req_type req,
   input  gbte_pkg::ctl_type ctl,
   output gbte_pkg::sts_type sts,
   output logic              rsp_valid,
   output gbte_pkg::rsp_type rsp
);

   localparam int AW = gbte_pkg::ADDR_W;
   localparam int CW = gbte_pkg::CNT_W;

   gbte_pkg::req_type req_ff;
   logic [CW-1:0]     bc_ff, bc_in;
   logic [CW-1:0]     ac_ff, ac_in;
   logic              rsp_valid_ff;
   gbte_pkg::rsp_type rsp_ff, rsp_in;

   logic [CW-1:0] len;
   logic [CW-1:0] idx_ext;
   logic [CW-1:0] after_idx;
   logic          in_before, in_after;

   logic          b_we, a_we;
   logic [AW-1:0] b_waddr, a_waddr, b_raddr, a_raddr;
   logic [7:0]    b_wdata, b_rdata, a_rdata;

   // request hold
   always_ff @(posedge clock) begin
      if (ctl.latch) req_ff <= req;
   end

   // stack depths
   always_ff @(posedge clock) begin
      if (reset) begin
         bc_ff <= '0;
         ac_ff <= '0;
      end else begin
         bc_ff <= bc_in;
         ac_ff <= ac_in;
      end
   end

   always_comb begin
      bc_in = bc_ff;
      ac_in = ac_ff;
      case (ctl.op)
         gbte_pkg::OP_FWD: begin
            bc_in = bc_ff + CW'(1);
            ac_in = ac_ff - CW'(1);
         end
         gbte_pkg::OP_BACK: begin
            bc_in = bc_ff - CW'(1);
            ac_in = ac_ff + CW'(1);
         end
         gbte_pkg::OP_INS:  bc_in = bc_ff + CW'(1);
         gbte_pkg::OP_DROP: ac_in = ac_ff - CW'(1);
         default: ;
      endcase
   end

   // store ports: reads follow the stack tops, or the indexed position for a read
   assign len       = bc_ff + ac_ff;
   assign idx_ext   = CW'(req_ff.index);
   assign after_idx = ac_ff - CW'(1) - (idx_ext - bc_ff);
   assign in_before = (idx_ext < bc_ff);
   assign in_after  = (idx_ext < len);

   assign b_we    = (ctl.op == gbte_pkg::OP_FWD) || (ctl.op == gbte_pkg::OP_INS);
   assign b_waddr = bc_ff[AW-1:0];
   assign b_wdata = (ctl.op == gbte_pkg::OP_INS) ? req_ff.ch : a_rdata;
   assign a_we    = (ctl.op == gbte_pkg::OP_BACK);
   assign a_waddr = ac_ff[AW-1:0];

   always_comb begin
      b_raddr = bc_in[AW-1:0] - AW'(1);
      a_raddr = ac_in[AW-1:0] - AW'(1);
      if (ctl.rd_index) begin
         b_raddr = req_ff.index[AW-1:0];
         a_raddr = after_idx[AW-1:0];
      end
   end

   gbte_ram #(.WIDTH(8), .DEPTH(gbte_pkg::CAPACITY)) u_before_ram (
      .clock (clock),
      .we    (b_we),
      .waddr (b_waddr),
      .wdata (b_wdata),
      .raddr (b_raddr),
      .rdata (b_rdata)
   );

   gbte_ram #(.WIDTH(8), .DEPTH(gbte_pkg::CAPACITY)) u_after_ram (
      .clock (clock),
      .we    (a_we),
      .waddr (a_waddr),
      .wdata (b_rdata),
      .raddr (a_raddr),
      .rdata (a_rdata)
   );

   // status toward the sequencer
   assign sts.cmd          = req_ff.cmd;
   assign sts.before_empty = (bc_ff == '0);
   assign sts.after_empty  = (ac_ff == '0);
   assign sts.full         = (len >= CW'(gbte_pkg::CAPACITY));
   assign sts.before_ws    = gbte_pkg::is_space(b_rdata);
   assign sts.after_ws     = gbte_pkg::is_space(a_rdata);

   // result beat
   always_comb begin
      rsp_in.char_out = 8'd0;
      rsp_in.cursor   = 9'(bc_in);
      rsp_in.length   = 9'(bc_in + ac_in);
      rsp_in.status   = gbte_pkg::ST_OK;
      if ((req_ff.cmd == gbte_pkg::CMD_INSERT) && sts.full) begin
         rsp_in.status = gbte_pkg::ST_FULL;
      end
      if (req_ff.cmd == gbte_pkg::CMD_READ) begin
         if (in_before) rsp_in.char_out = b_rdata;
         else if (in_after) rsp_in.char_out = a_rdata;
         else rsp_in.status = gbte_pkg::ST_RANGE;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) rsp_valid_ff <= 1'b0;
      else rsp_valid_ff <= ctl.respond;
   end

   always_ff @(posedge clock) begin
      if (ctl.respond) rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;

   // the text never outgrows the stores
   a_len: assert property (@(posedge clock) disable iff (reset)
      len <= CW'(gbte_pkg::CAPACITY))
      else $error("length beyond capacity");

   // moves and drops only from a non-empty stack
   a_pop: assert property (@(posedge clock) disable iff (reset)
      (((ctl.op != gbte_pkg::OP_FWD) && (ctl.op != gbte_pkg::OP_DROP)) || !sts.after_empty) &&
      ((ctl.op != gbte_pkg::OP_BACK) || !sts.before_empty))
      else $error("pop from empty stack");

   // inserts never go into a full buffer
   a_ins: assert property (@(posedge clock) disable iff (reset)
      (ctl.op == gbte_pkg::OP_INS) |-> !sts.full)
      else $error("insert into full buffer");

endmodule

### hdl/gap_buffer_text_editor.sv
// top level of the gap buffer text editor: sequencer plus two-stack datapath
// depends on gbte_pkg, gbte_ctrl, gbte_dpath (and gbte_ram below it)

// A command is taken when start is high while busy is low; busy stays high until
// its single result beat, which shows on rsp_data for exactly one cycle with
// rsp_valid high and cannot be held off. Single-step commands (forward, back,
// insert, delete, unused codes) respond from the execute state; a read adds a
// read-out state. Move to start/end, word moves and delete word move or drop one
// character per cycle through the store read port until they stop and respond.
// The stores start out unwritten and need no clearing pass.

module gap_buffer_text_editor (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  gbte_pkg::req_type req_data,
   output logic              rsp_valid,
   output gbte_pkg::rsp_type rsp_data
);

   gbte_pkg::ctl_type ctl;
   gbte_pkg::sts_type sts;

   gbte_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .busy  (busy),
      .sts   (sts),
      .ctl   (ctl)
   );

   gbte_dpath u_dpath (
      .clock     (clock),
      .reset     (reset),
      .req       (req_data),
      .ctl       (ctl),
      .sts       (sts),
      .rsp_valid (rsp_valid),
      .rsp       (rsp_data)
   );

endmodule

### verif/gap_buffer_text_editor_test.sv
// testbench for gap_buffer_text_editor: directed and random command traffic
// against a self-checking two-stack text model; depends on gbte_pkg and the RTL

`timescale 1ns / 100ps

module gap_buffer_text_editor_test;

   // unused command codes and whitespace bounds
   localparam logic [3:0] CMD_UNUSED_FIRST = 4'd10;
   localparam logic [3:0] CMD_UNUSED_LAST  = 4'd15;
   localparam logic [7:0] CHAR_SPACE       = 8'h20;
   localparam logic [7:0] CHAR_TAB         = 8'h09;
   localparam logic [7:0] CHAR_CR          = 8'h0D;

   logic              clock = 1'b0;
   logic              reset;
   logic              start;
   logic              busy;
   gbte_pkg::req_type req_data;
   logic              rsp_valid;
   gbte_pkg::rsp_type rsp_data;
   bit                quiet;

   // text model and queue of expected result beats
   class edit_scoreboard;
      logic [7:0]        before_text [gbte_pkg::CAPACITY];
      logic [7:0]        after_text  [gbte_pkg::CAPACITY];
      int unsigned       before_depth = 0;
      int unsigned       after_depth  = 0;
      gbte_pkg::rsp_type expected_q[$];
      int unsigned       fault_count   = 0;
      int unsigned       command_count = 0;
      int unsigned       result_count  = 0;
      int unsigned       full_drops    = 0;
      int unsigned       range_misses  = 0;

      function bit is_blank(input logic [7:0] c);
         return (c == CHAR_SPACE) || ((c >= CHAR_TAB) && (c <= CHAR_CR));
      endfunction

      function int unsigned text_length();
         return before_depth + after_depth;
      endfunction

      function int unsigned pending();
         return expected_q.size();
      endfunction

      function void step_forward();
         if (after_depth > 0) begin
            after_depth--;
            before_text[before_depth] = after_text[after_depth];
            before_depth++;
         end
      endfunction

      function void step_backward();
         if (before_depth > 0) begin
            before_depth--;
            after_text[after_depth] = before_text[before_depth];
            after_depth++;
         end
      endfunction

      function void drop_next();
         if (after_depth > 0)
            after_depth--;
      endfunction

      // apply one accepted command and queue its expected beat
      function void take_command(input gbte_pkg::req_type r);
         gbte_pkg::rsp_type e;
         e = '0;
         command_count++;
         case (r.cmd)
            gbte_pkg::CMD_FWD:  step_forward();
            gbte_pkg::CMD_BACK: step_backward();
            gbte_pkg::CMD_START: begin
               while (before_depth > 0)
                  step_backward();
            end
            gbte_pkg::CMD_END: begin
               while (after_depth > 0)
                  step_forward();
            end
            gbte_pkg::CMD_INSERT: begin
               if (text_length() >= gbte_pkg::CAPACITY) begin
                  e.status = gbte_pkg::ST_FULL;
                  full_drops++;
               end else begin
                  before_text[before_depth] = r.ch;
                  before_depth++;
               end
            end
            gbte_pkg::CMD_DELETE: drop_next();
            gbte_pkg::CMD_WORD_FWD: begin
               step_forward();
               while (after_depth > 0 && !is_blank(after_text[after_depth - 1]))
                  step_forward();
            end
            gbte_pkg::CMD_WORD_BACK: begin
               step_backward();
               while (before_depth > 0 && !is_blank(before_text[before_depth - 1]))
                  step_backward();
            end
            gbte_pkg::CMD_DEL_WORD: begin
               drop_next();
               while (after_depth > 0 && !is_blank(after_text[after_depth - 1]))
                  drop_next();
            end
            gbte_pkg::CMD_READ: begin
               if (r.index < before_depth) begin
                  e.char_out = before_text[r.index];
               end else if (r.index < text_length()) begin
                  e.char_out = after_text[after_depth - 1 - (r.index - before_depth)];
               end else begin
                  e.status = gbte_pkg::ST_RANGE;
                  range_misses++;
               end
            end
            default: ;
         endcase
         e.cursor = 9'(before_depth);
         e.length = 9'(text_length());
         expected_q.push_back(e);
      endfunction

      // compare one result beat with the oldest expectation
      function void check_result(input gbte_pkg::rsp_type got);
         gbte_pkg::rsp_type e;
         result_count++;
         if (expected_q.size() == 0) begin
            $error("result beat with nothing outstanding: %p", got);
            fault_count++;
            return;
         end
         e = expected_q.pop_front();
         if (got.char_out !== e.char_out) begin
            $error("char_out mismatch: expected %0d, actual %0d", e.char_out, got.char_out);
            fault_count++;
         end
         if (got.cursor !== e.cursor) begin
            $error("cursor mismatch: expected %0d, actual %0d", e.cursor, got.cursor);
            fault_count++;
         end
         if (got.length !== e.length) begin
            $error("length mismatch: expected %0d, actual %0d", e.length, got.length);
            fault_count++;
         end
         if (got.status !== e.status) begin
            $error("status mismatch: expected %0d, actual %0d", e.status, got.status);
            fault_count++;
         end
      endfunction
   endclass

   edit_scoreboard board = new();

   gap_buffer_text_editor u_top (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

   always #5 clock = ~clock;

   // result monitor
   always @(posedge clock) begin
      if (!reset && rsp_valid)
         board.check_result(rsp_data);
   end

   function automatic gbte_pkg::req_type cmd_item(input logic [3:0] cmd,
                                                  input logic [7:0] ch,
                                                  input logic [7:0] index);
      gbte_pkg::req_type r;
      r.cmd   = cmd;
      r.ch    = ch;
      r.index = index;
      return r;
   endfunction

   // idle cycles before a beat: mostly none, some short, a few long
   function automatic int unsigned pick_gap();
      int unsigned roll;
      roll = $urandom_range(0, 99);
      if (quiet || roll < 55)
         return 0;
      if (roll < 90)
         return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // text-like bytes: letters, blanks and the odd arbitrary byte
   function automatic logic [7:0] text_char();
      int unsigned roll;
      roll = $urandom_range(0, 99);
      if (roll < 70)
         return 8'("a") + 8'($urandom_range(0, 25));
      if (roll < 85)
         return CHAR_SPACE;
      if (roll < 93)
         return 8'($urandom_range(CHAR_TAB, CHAR_CR));
      return 8'($urandom_range(0, 255));
   endfunction

   // random command weighted by the current text length
   function automatic gbte_pkg::req_type random_command();
      gbte_pkg::req_type r;
      int unsigned       len;
      int unsigned       roll;
      len     = board.text_length();
      r.ch    = 8'($urandom_range(0, 255));
      r.index = 8'($urandom_range(0, 255));
      if ($urandom_range(0, 99) < ((len < 160) ? 30 : 8)) begin
         r.cmd = gbte_pkg::CMD_INSERT;
         r.ch  = text_char();
         return r;
      end
      roll = $urandom_range(0, 99);
      if (roll < 8)
         r.cmd = gbte_pkg::CMD_FWD;
      else if (roll < 16)
         r.cmd = gbte_pkg::CMD_BACK;
      else if (roll < 20)
         r.cmd = gbte_pkg::CMD_START;
      else if (roll < 24)
         r.cmd = gbte_pkg::CMD_END;
      else if (roll < 34)
         r.cmd = gbte_pkg::CMD_DELETE;
      else if (roll < 44)
         r.cmd = gbte_pkg::CMD_WORD_FWD;
      else if (roll < 54)
         r.cmd = gbte_pkg::CMD_WORD_BACK;
      else if (roll < 62)
         r.cmd = gbte_pkg::CMD_DEL_WORD;
      else if (roll < 97) begin
         r.cmd = gbte_pkg::CMD_READ;
         if (len > 0 && $urandom_range(0, 4) != 0)
            r.index = 8'($urandom_range(0, len - 1));
      end else
         r.cmd = 4'($urandom_range(CMD_UNUSED_FIRST, CMD_UNUSED_LAST));
      return r;
   endfunction

   // drive one command beat and wait until it is taken
   task automatic issue(input gbte_pkg::req_type r, input int unsigned gap);
      if (gap > 0) begin
         @(negedge clock);
         start <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      start    <= 1'b1;
      req_data <= r;
      do @(posedge clock); while (busy);
      board.take_command(r);
   endtask

   // hold off until every outstanding result has come back
   task automatic settle_all();
      @(negedge clock);
      start <= 1'b0;
      while (board.pending() != 0)
         @(posedge clock);
   endtask

   // edges, every command and the empty buffer cases
   task automatic directed_commands();
      issue(cmd_item(gbte_pkg::CMD_FWD, 8'h00, 8'h00), 0);
      issue(cmd_item(gbte_pkg::CMD_BACK, 8'h00, 8'h00), 0);
      issue(cmd_item(gbte_pkg::CMD_DELETE, 8'h00, 8'h00), 0);
      issue(cmd_item(gbte_pkg::CMD_WORD_FWD, 8'h00, 8'h00), 0);
      issue(cmd_item(gbte_pkg::CMD_WORD_BACK, 8'h00, 8'h00), 0);
      issue(cmd_item(gbte_pkg::CMD_DEL_WORD, 8'h00, 8'h00), 0);
      issue(cmd_item(gbte_pkg::CMD_START, 8'h00, 8'h00), 0);
      issue(cmd_item(gbte_pkg::CMD_END, 8'h00, 8'h00), 0);
      issue(cmd_item(gbte_pkg::CMD_READ, 8'h00, 8'h00), 0);
      issue(cmd_item(gbte_pkg::CMD_INSERT, "h", 8'h00), 0);
      issue(cmd_item(gbte_pkg::CMD_INSERT, "i", 8'h00), 0);
      issue(cmd_item(gbte_pkg::CMD_INSERT, CHAR_SPACE, 8'h00), 0);
      issue(cmd_item(gbte_pkg::CMD_INSERT, 8'hFF, 8'h00), 2);
      issue(cmd_item(gbte_pkg::CMD_INSERT, CHAR_TAB, 8'h00), 0);
      issue(cmd_item(gbte_pkg::CMD_INSERT, 8'h00, 8'h00), 0);
      issue(cmd_item(gbte_pkg::CMD_INSERT, "x", 8'h00), 0);
      issue(cmd_item(gbte_pkg::CMD_READ, 8'h00, 8'h06), 0);
      issue(cmd_item(gbte_pkg::CMD_READ, 8'h00, 8'hFF), 0);
      issue(cmd_item(gbte_pkg::CMD_WORD_BACK, 8'h00, 8'h00), 0);
      issue(cmd_item(gbte_pkg::CMD_WORD_BACK, 8'h00, 8'h00), 1);
      issue(cmd_item(gbte_pkg::CMD_READ, 8'h00, 8'h03), 0);
      issue(cmd_item(gbte_pkg::CMD_WORD_FWD, 8'h00, 8'h00), 0);
      issue(cmd_item(gbte_pkg::CMD_START, 8'h00, 8'h00), 0);
      issue(cmd_item(gbte_pkg::CMD_DEL_WORD, 8'h00, 8'h00), 0);
      issue(cmd_item(gbte_pkg::CMD_END, 8'h00, 8'h00), 0);
      issue(cmd_item(CMD_UNUSED_FIRST, 8'hFF, 8'hFF), 0);
      issue(cmd_item(CMD_UNUSED_LAST, 8'h00, 8'h00), 0);
   endtask

   // grow the text to capacity, then work on a full buffer
   task automatic fill_to_full();
      while (board.text_length() < gbte_pkg::CAPACITY)
         issue(cmd_item(gbte_pkg::CMD_INSERT, text_char(), 8'($urandom_range(0, 255))),
               pick_gap());
      repeat (3) issue(cmd_item(gbte_pkg::CMD_INSERT, text_char(), 8'h00), pick_gap());
      issue(cmd_item(gbte_pkg::CMD_READ, 8'h00, 8'hFF), pick_gap());
      issue(cmd_item(gbte_pkg::CMD_READ, 8'h00, 8'h00), pick_gap());
      issue(cmd_item(gbte_pkg::CMD_END, 8'h00, 8'h00), pick_gap());
      issue(cmd_item(gbte_pkg::CMD_WORD_BACK, 8'h00, 8'h00), pick_gap());
      issue(cmd_item(gbte_pkg::CMD_START, 8'h00, 8'h00), pick_gap());
      issue(cmd_item(gbte_pkg::CMD_WORD_FWD, 8'h00, 8'h00), pick_gap());
      issue(cmd_item(gbte_pkg::CMD_READ, 8'h00, 8'hFF), pick_gap());
      issue(cmd_item(gbte_pkg::CMD_END, 8'h00, 8'h00), pick_gap());
   endtask

   // empty the text from the front, word by word or one character at a time
   task automatic drain_text();
      issue(cmd_item(gbte_pkg::CMD_START, 8'h00, 8'h00), pick_gap());
      while (board.text_length() > 0) begin
         if ($urandom_range(0, 3) == 0)
            issue(cmd_item(gbte_pkg::CMD_DELETE, 8'h00, 8'h00), pick_gap());
         else
            issue(cmd_item(gbte_pkg::CMD_DEL_WORD, 8'h00, 8'h00), pick_gap());
      end
   endtask

   // main sequence
   initial begin
      start    = 1'b0;
      req_data = '0;
      reset    = 1'b1;
      quiet    = 1'b0;
      repeat (4) @(negedge clock);
      reset <= 1'b0;
      directed_commands();
      settle_all();
      for (int phase = 0; phase < 5; phase++) begin
         quiet = (phase == 2);
         repeat (280) begin
            issue(random_command(), pick_gap());
            if ($urandom_range(0, 59) == 0)
               settle_all();
         end
         if (phase == 1 || phase == 3) begin
            fill_to_full();
            drain_text();
         end
         settle_all();
      end
      repeat (gbte_pkg::CAPACITY + 8) @(posedge clock);
      if (board.pending() != 0) begin
         $error("%0d expected results never arrived", board.pending());
         board.fault_count++;
      end
      $display("ran %0d commands with %0d result beats checked, %0d inserts on a full buffer",
               board.command_count, board.result_count, board.full_drops);
      $display("and %0d reads past the end of the text", board.range_misses);
      if (board.fault_count == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

   // watchdog
   initial begin
      #50_000_000;
      $display("simulation failed");
      $finish;
   end

endmodule
